FILE: rtl/core/ialu_pkg.sv
// Shared types and constants for the iterative integer ALU.
// Used by ialu_addsub, ialu_ctrl and iterative_integer_alu; no dependencies.
`timescale 1ns / 1ps

package ialu_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	// operation codes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_REM = 3'd4;
	localparam logic [2:0] OP_POW = 3'd5;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_INVALID  = 2'd1;
	localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

	typedef struct packed {
		logic [2:0]                   action;
		logic signed [DATA_WIDTH-1:0] operand_a;
		logic signed [DATA_WIDTH-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] result_value;
		logic [1:0]                   error_code;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADDSUB,
		S_MUL,
		S_NEGA,
		S_NEGB,
		S_DIV,
		S_FIX,
		S_PCHK,
		S_PACC,
		S_PSQ,
		S_DONE
	} state_t;

	// datapath -> sequencer
	typedef struct packed {
		logic b_zero;    // request operand_b is zero
		logic b_nonpos;  // request operand_b is zero or negative
		logic exp_zero;  // remaining exponent is zero
		logic exp_lsb;   // low bit of remaining exponent
	} status_t;

	// sequencer -> datapath
	typedef struct packed {
		state_t state;
		logic   last;    // final pass of a bit loop
		logic   busy;
		logic   done;
	} ctrl_t;

endpackage

FILE: rtl/core/ialu_addsub.sv
// Shared adder/subtractor with carry out, reused by every operation.
// Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_addsub
	import ialu_pkg::*;
(
	input  logic [DATA_WIDTH-1:0] x,
	input  logic [DATA_WIDTH-1:0] y,
	input  logic                  sub,
	output logic [DATA_WIDTH:0]   sum
);

	logic [DATA_WIDTH-1:0] y_eff;

	assign y_eff = sub ? ~y : y;
	// carry out set on subtract means x >= y (unsigned)
	assign sum = {1'b0, x} + {1'b0, y_eff} + {{DATA_WIDTH{1'b0}}, sub};

endmodule

FILE: rtl/core/ialu_ctrl.sv
// Sequencer for the iterative ALU: state machine plus bit-loop counter.
// Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_ctrl
	import ialu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] action,
	input  status_t    status,
	output ctrl_t      ctrl
);

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             last;
	logic             looping;

	assign last    = (cnt_q == CNT_W'(DATA_WIDTH - 1));
	assign looping = (state_q == S_MUL) || (state_q == S_DIV) ||
	                 (state_q == S_PACC) || (state_q == S_PSQ);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (action)
						OP_ADD, OP_SUB: state_nxt = S_ADDSUB;
						OP_MUL:         state_nxt = S_MUL;
						OP_DIV, OP_REM: state_nxt = status.b_zero ? S_DONE : S_NEGA;
						OP_POW:         state_nxt = status.b_nonpos ? S_DONE : S_PCHK;
						default:        state_nxt = S_DONE;
					endcase
				end
			end
			S_ADDSUB: state_nxt = S_DONE;
			S_MUL:    if (last) state_nxt = S_DONE;
			S_NEGA:   state_nxt = S_NEGB;
			S_NEGB:   state_nxt = S_DIV;
			S_DIV:    if (last) state_nxt = S_FIX;
			S_FIX:    state_nxt = S_DONE;
			S_PCHK: begin
				if (status.exp_zero)
					state_nxt = S_DONE;
				else if (status.exp_lsb)
					state_nxt = S_PACC;
				else
					state_nxt = S_PSQ;
			end
			S_PACC:   if (last) state_nxt = S_PCHK;
			S_PSQ:    if (last) state_nxt = S_PCHK;
			S_DONE:   state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.state = state_q;
		ctrl.last  = last;
		ctrl.busy  = (state_q != S_IDLE);
		ctrl.done  = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (looping && !last)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

endmodule

FILE: rtl/core/iterative_integer_alu.sv
// Top level of the iterative integer ALU: operand registers and datapath muxing.
// Depends on ialu_pkg, ialu_addsub and ialu_ctrl.
`timescale 1ns / 1ps

// Sequence from acceptance to the done strobe: add/sub take one adder pass; an
// invalid op, a zero divisor or an exponent <= 0 go straight to done; multiply
// runs its shift-add loop; divide/remainder run two negate passes, 32 restoring
// steps and a sign fix. Power runs a multiply per set exponent bit plus a square
// per higher bit, each after a check. All passes go through the one adder.
// A new transaction is taken the cycle after done. Reset clears the sequencer.
module iterative_integer_alu
	import ialu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t response
);

	localparam int DW = DATA_WIDTH;

	ctrl_t   ctrl;
	status_t status;

	// working registers
	// prod_q:   product accumulator / partial remainder
	// mcand_q:  multiplicand (shifts left) / divisor
	// mplier_q: multiplier (shifts right) / dividend, quotient shifts in
	logic [2:0]    op_q;
	logic [DW-1:0] prod_q;
	logic [DW-1:0] mcand_q;
	logic [DW-1:0] mplier_q;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] sq_q;
	logic [DW-1:0] exp_q;
	logic          a_neg_q;
	logic          b_neg_q;
	logic [DW-1:0] res_q;
	logic [1:0]    err_q;

	logic [DW-1:0] ux;
	logic [DW-1:0] uy;
	logic          usub;
	logic [DW:0]   usum;
	logic [DW-1:0] div_shift;
	logic          div_geq;
	logic [DW-1:0] fix_val;
	logic          fix_neg;
	logic          accept;

	assign accept = start && !ctrl.busy;

	assign status.b_zero   = (request.operand_b == '0);
	assign status.b_nonpos = (request.operand_b == '0) || request.operand_b[DW-1];
	assign status.exp_zero = (exp_q == '0);
	assign status.exp_lsb  = exp_q[0];

	ialu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (request.action),
		.status (status),
		.ctrl   (ctrl)
	);

	assign div_shift = {prod_q[DW-2:0], mplier_q[DW-1]};
	assign div_geq   = usum[DW];
	assign fix_val   = (op_q == OP_DIV) ? mplier_q : prod_q;
	assign fix_neg   = (op_q == OP_DIV) ? (a_neg_q ^ b_neg_q) : a_neg_q;

	// operand selection for the shared adder
	always_comb begin
		ux   = '0;
		uy   = '0;
		usub = 1'b0;
		case (ctrl.state)
			S_ADDSUB: begin
				ux   = mplier_q;
				uy   = mcand_q;
				usub = (op_q == OP_SUB);
			end
			S_MUL, S_PACC, S_PSQ: begin
				ux = prod_q;
				uy = mplier_q[0] ? mcand_q : '0;
			end
			S_NEGA: begin
				uy   = mplier_q;
				usub = 1'b1;
			end
			S_NEGB: begin
				uy   = mcand_q;
				usub = 1'b1;
			end
			S_DIV: begin
				// partial remainder stays below the divisor, so its top bit is clear
				ux   = div_shift;
				uy   = mcand_q;
				usub = 1'b1;
			end
			S_FIX: begin
				uy   = fix_val;
				usub = 1'b1;
			end
			default: begin
				ux   = '0;
				uy   = '0;
				usub = 1'b0;
			end
		endcase
	end

	ialu_addsub u_addsub (
		.x   (ux),
		.y   (uy),
		.sub (usub),
		.sum (usum)
	);

	// datapath registers carry no reset
	always_ff @(posedge clk) begin
		case (ctrl.state)
			S_IDLE: begin
				if (accept) begin
					op_q     <= request.action;
					prod_q   <= '0;
					mcand_q  <= request.operand_b;
					mplier_q <= request.operand_a;
					acc_q    <= DW'(1);
					sq_q     <= request.operand_a;
					exp_q    <= request.operand_b;
					a_neg_q  <= request.operand_a[DW-1];
					b_neg_q  <= request.operand_b[DW-1];
					// early-exit results preset here
					res_q    <= (request.action == OP_POW && status.b_nonpos) ? DW'(1) : '0;
					case (request.action)
						OP_ADD, OP_SUB, OP_MUL, OP_POW: err_q <= ERR_NONE;
						OP_DIV, OP_REM: err_q <= status.b_zero ? ERR_DIV_ZERO : ERR_NONE;
						default:        err_q <= ERR_INVALID;
					endcase
				end
			end
			S_ADDSUB: res_q <= usum[DW-1:0];
			S_MUL, S_PACC, S_PSQ: begin
				prod_q   <= usum[DW-1:0];
				mcand_q  <= {mcand_q[DW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[DW-1:1]};
				if (ctrl.last) begin
					if (ctrl.state == S_MUL)
						res_q <= usum[DW-1:0];
					else if (ctrl.state == S_PACC) begin
						acc_q <= usum[DW-1:0];
						exp_q <= {exp_q[DW-1:1], 1'b0};
					end else begin
						sq_q  <= usum[DW-1:0];
						exp_q <= {1'b0, exp_q[DW-1:1]};
					end
				end
			end
			S_NEGA: if (a_neg_q) mplier_q <= usum[DW-1:0];
			S_NEGB: if (b_neg_q) mcand_q <= usum[DW-1:0];
			S_DIV: begin
				prod_q   <= div_geq ? usum[DW-1:0] : div_shift;
				mplier_q <= {mplier_q[DW-2:0], div_geq};
			end
			S_FIX: res_q <= fix_neg ? usum[DW-1:0] : fix_val;
			S_PCHK: begin
				// set up the next multiply: acc*sq or sq*sq
				prod_q   <= '0;
				mcand_q  <= sq_q;
				mplier_q <= exp_q[0] ? acc_q : sq_q;
				if (exp_q == '0)
					res_q <= acc_q;
			end
			default: begin
			end
		endcase
	end

	assign busy                  = ctrl.busy;
	assign done                  = ctrl.done;
	assign response.result_value = res_q;
	assign response.error_code   = err_q;

`ifndef SYNTHESIS
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("done not followed by idle");

	a_done_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !done)
		else $error("done strobe while idle");

	a_err_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && response.error_code != ERR_NONE) |-> (response.result_value == '0))
		else $error("error flagged with nonzero result");

	a_add_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.action == OP_ADD) |-> ##2 done)
		else $error("add did not finish in two cycles");
`endif

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for iterative_integer_alu: a queued driver, a result monitor
// and a predictor for add, subtract, multiply, divide, remainder and power.
// Depends on ialu_pkg and the iterative_integer_alu RTL.
`timescale 1ns / 1ps

module tb_top;
	import ialu_pkg::*;

	localparam int W = DATA_WIDTH;

	// action codes the block must reject
	localparam logic [2:0] OP_RSVD_A = 3'd6;
	localparam logic [2:0] OP_RSVD_B = 3'd7;

	localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAX_VAL = ~MIN_VAL;

	// A power with a full-width exponent runs a multiply per set bit and a square
	// per higher bit without any handshake, so the watchdog sits well above that run.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 64;
	localparam int RANDOM_ITEMS   = 1330;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t response;

	req_t pending_ops[$];   // transactions not yet taken by the block
	bit   wait_drain[$];    // per pending transaction: hold until all results are back
	rsp_t expected_rsp[$];  // predicted responses, oldest first

	int burst_left = 1;
	int gap_left = 0;
	int idle_cycles = 0;
	int mismatches = 0;

	iterative_integer_alu i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Expected response for one transaction. Division works on magnitudes and
	// puts the sign back, so truncation is toward zero and the remainder
	// follows the dividend. Power is square-and-multiply over every bit.
	function automatic rsp_t alu_predict(req_t rq);
		rsp_t r;
		logic [W-1:0] a, b, ua, ub, mag, acc, sq;
		logic neg;
		a = rq.operand_a;
		b = rq.operand_b;
		r.result_value = '0;
		r.error_code = ERR_NONE;
		case (rq.action)
			OP_ADD: r.result_value = a + b;
			OP_SUB: r.result_value = a - b;
			OP_MUL: r.result_value = a * b;
			OP_DIV, OP_REM: begin
				if (b == '0) begin
					r.error_code = ERR_DIV_ZERO;
				end else begin
					ua = a[W-1] ? -a : a;
					ub = b[W-1] ? -b : b;
					if (rq.action == OP_DIV) begin
						mag = ua / ub;
						neg = a[W-1] ^ b[W-1];
					end else begin
						mag = ua % ub;
						neg = a[W-1];
					end
					r.result_value = neg ? -mag : mag;
				end
			end
			OP_POW: begin
				if (b == '0 || b[W-1]) begin
					r.result_value = 1;
				end else begin
					acc = 1;
					sq = a;
					for (int i = 0; i < W; i++) begin
						if (b[i])
							acc = acc * sq;
						sq = sq * sq;
					end
					r.result_value = acc;
				end
			end
			default: r.error_code = ERR_INVALID;
		endcase
		return r;
	endfunction

	// operand mix: half full random, plus small values, extremes, powers of two
	function automatic logic [W-1:0] rand_operand();
		logic [W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = W'({$urandom, $urandom});
			5, 6: v = $urandom_range(0, 64) - 32;
			7: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = 1;
					2: v = '1;
					3: v = MIN_VAL;
					default: v = MAX_VAL;
				endcase
			end
			default: begin
				v = 1;
				v = v << $urandom_range(0, W-1);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic queue_op(logic [2:0] act, logic [W-1:0] a, logic [W-1:0] b, bit drain);
		req_t rq;
		rq.action = act;
		rq.operand_a = a;
		rq.operand_b = b;
		pending_ops.push_back(rq);
		wait_drain.push_back(drain);
	endtask

	// Driver: a transaction is taken at an edge with start high and busy low.
	// Traffic comes in bursts with random gaps; a flagged transaction is held
	// back until every outstanding response has arrived.
	always @(posedge clk) begin
		bit taken;
		taken = arst_n && start && !busy;
		if (taken) begin
			expected_rsp.push_back(alu_predict(request));
			void'(pending_ops.pop_front());
			void'(wait_drain.pop_front());
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 8);
				case ($urandom_range(0, 7))
					0, 1: gap_left = 0;
					2: gap_left = $urandom_range(13, 40);
					default: gap_left = $urandom_range(1, 12);
				endcase
			end
		end
		if (!arst_n) begin
			start <= 1'b0;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left--;
		end else if (pending_ops.size() > 0 && (!wait_drain[0] || expected_rsp.size() == 0)) begin
			start <= 1'b1;
			request <= pending_ops[0];
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: done marks a response for exactly one cycle; check it against
	// the oldest prediction.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual value %0d error %0d",
					$time, response.result_value, response.error_code);
				mismatches++;
			end else begin
				exp_rsp = expected_rsp.pop_front();
				if (response.result_value !== exp_rsp.result_value) begin
					$display("%0t: result_value mismatch, expected %0d actual %0d",
						$time, exp_rsp.result_value, response.result_value);
					mismatches++;
				end
				if (response.error_code !== exp_rsp.error_code) begin
					$display("%0t: error_code mismatch, expected %0d actual %0d",
						$time, exp_rsp.error_code, response.error_code);
					mismatches++;
				end
			end
		end
	end

	// watchdog: cycles since the last transaction or response
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		logic [2:0] act;
		logic [W-1:0] a, b;
		int pick;

		// directed: wrap-around, negative multiplier, signed division corners,
		// zero divisor, most negative over minus one, nonpositive exponents,
		// reserved action codes
		queue_op(OP_ADD, MAX_VAL, 1, 1'b0);
		queue_op(OP_ADD, MIN_VAL, '1, 1'b0);
		queue_op(OP_SUB, MIN_VAL, 1, 1'b0);
		queue_op(OP_SUB, '0, MIN_VAL, 1'b0);
		queue_op(OP_MUL, 12345, -678, 1'b0);
		queue_op(OP_MUL, MIN_VAL, '1, 1'b0);
		queue_op(OP_MUL, MAX_VAL, MAX_VAL, 1'b0);
		queue_op(OP_DIV, 7, '0, 1'b0);
		queue_op(OP_DIV, -7, 2, 1'b0);
		queue_op(OP_DIV, 7, -2, 1'b0);
		queue_op(OP_DIV, MIN_VAL, '1, 1'b0);
		queue_op(OP_DIV, -6, 3, 1'b0);
		queue_op(OP_DIV, MAX_VAL, MIN_VAL, 1'b0);
		queue_op(OP_REM, 7, '0, 1'b0);
		queue_op(OP_REM, -7, 2, 1'b0);
		queue_op(OP_REM, 7, -2, 1'b0);
		queue_op(OP_REM, MIN_VAL, '1, 1'b0);
		queue_op(OP_REM, -6, -3, 1'b0);
		queue_op(OP_POW, '0, '0, 1'b0);
		queue_op(OP_POW, 5, -3, 1'b0);
		queue_op(OP_POW, -3, 5, 1'b0);
		queue_op(OP_POW, 2, W, 1'b0);
		queue_op(OP_POW, 3, MAX_VAL, 1'b0);
		queue_op(OP_RSVD_A, MAX_VAL, MIN_VAL, 1'b0);
		queue_op(OP_RSVD_B, '1, '1, 1'b0);

		// random part; every 250th transaction waits for the pipe to drain
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 15);
			a = rand_operand();
			b = rand_operand();
			case (pick)
				0, 1: act = OP_ADD;
				2, 3: act = OP_SUB;
				4, 5, 6: act = OP_MUL;
				7, 8, 9: act = OP_DIV;
				10, 11, 12: act = OP_REM;
				13, 14: act = OP_POW;
				default: act = $urandom_range(0, 1) ? OP_RSVD_B : OP_RSVD_A;
			endcase
			if (act == OP_DIV || act == OP_REM) begin
				case ($urandom_range(0, 9))
					0: b = '0;
					1: b = '1;
					default: ;
				endcase
			end
			// keep most exponents short; a full-width one runs a multiply per set bit and a square per higher bit
			if (act == OP_POW && $urandom_range(0, 9) < 7)
				b = $urandom_range(0, 44) - 4;
			queue_op(act, a, b, (n % 250) == 0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (!(pending_ops.size() == 0 && expected_rsp.size() == 0)
			&& idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);

		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d pending, %0d responses outstanding",
				$time, pending_ops.size(), expected_rsp.size());
			$display("tb: failure");
		end else begin
			// catch any stray response after the last one
			repeat (TAIL_CYCLES) @(posedge clk);
			if (mismatches == 0)
				$display("tb: success");
			else
				$display("tb: failure");
		end
		$finish;
	end

endmodule
